// ===== src/lrip_pkg.sv =====
// shared types and constants for the lidar range image projection block
package lrip_pkg;

  localparam int SQ_STEPS = 21;
  localparam int CORDIC_STEPS = 16;

  localparam logic signed [20:0] Q_PI      = 21'sd205887;
  localparam logic signed [20:0] Q_HALF_PI = 21'sd102944;
  localparam logic signed [20:0] Q_TWO_PI  = 21'sd411775;
  localparam logic [19:0] COL_DEN = 20'd823550;

  localparam logic signed [20:0] ATAN_TAB [CORDIC_STEPS] = '{
    21'sd51472, 21'sd30385, 21'sd16055, 21'sd8150, 21'sd4091, 21'sd2047, 21'sd1024,
    21'sd512, 21'sd256, 21'sd128, 21'sd64, 21'sd32, 21'sd16, 21'sd8, 21'sd4, 21'sd2
  };

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_MINR   = 2'd2;

  localparam logic [17:0] OFFSET_RST = 18'd17272;
  localparam logic [17:0] STEP_RST   = 18'd2288;
  localparam logic [19:0] MINR_RST   = 20'd102;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ROW  = 2'd1;
  localparam logic [1:0] ST_COL  = 2'd2;
  localparam logic [1:0] ST_NEAR = 2'd3;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic [19:0]        h;
    logic [19:0]        rng;
    logic signed [20:0] elev;
    logic signed [20:0] azim;
    logic               rneg;
    logic               rbad;
    logic               cneg;
    logic [12:0]        cq;
    logic [6:0]         rq;
    logic [1:0]         status;
    logic [6:0]         row;
    logic [11:0]        col;
    logic [6:0]         qr;
    logic [11:0]        qc;
    logic [3:0]         rr;
    logic [3:0]         rc;
    logic [14:0]        tile;
    logic [14:0]        img;
    logic [14:0]        patch;
  } pt_t;

  typedef struct packed {
    logic vld;
    pt_t  d;
  } stg_t;

endpackage

// ===== src/lrip_in_if.sv =====
// point input channel
interface lrip_in_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] x_pos;
  logic signed [19:0] y_pos;
  logic signed [19:0] z_pos;

  modport source (output valid, output x_pos, output y_pos, output z_pos, input ready);
  modport sink (input valid, input x_pos, input y_pos, input z_pos, output ready);
endinterface

// ===== src/lrip_out_if.sv =====
// projection result channel
interface lrip_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  row;
  logic [10:0] column;
  logic [19:0] distance;
  logic [14:0] image_index;
  logic [14:0] patch_index;

  modport source (output valid, output status, output row, output column, output distance,
                  output image_index, output patch_index, input ready);
  modport sink (input valid, input status, input row, input column, input distance,
                input image_index, input patch_index, output ready);
endinterface

// ===== src/lrip_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module lrip_div #(
  parameter int NW = 22,
  parameter int DW = 18,
  parameter int QB = 4
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);
  localparam int CW = (NW > DW + QB) ? NW : DW + QB;

  logic [NW-1:0] rm_r [QB];
  logic [NW-1:0] rm_nxt [QB];
  logic [QB-1:0] qt_r [QB];
  logic [QB-1:0] qt_nxt [QB];

  always_comb begin
    logic [CW-1:0] cr;
    logic [CW-1:0] sd;
    logic [CW-1:0] df;
    logic [QB-1:0] pq;
    for (int j = 0; j < QB; j++) begin
      if (j == 0) begin
        cr = CW'(num);
        pq = '0;
      end else begin
        cr = CW'(rm_r[j-1]);
        pq = qt_r[j-1];
      end
      sd = CW'(den) << (QB - 1 - j);
      df = cr - sd;
      if (cr >= sd) begin
        rm_nxt[j] = df[NW-1:0];
        pq[QB-1-j] = 1'b1;
      end else begin
        rm_nxt[j] = cr[NW-1:0];
      end
      qt_nxt[j] = pq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm_r <= rm_nxt;
      qt_r <= qt_nxt;
    end
  end

  assign quo = qt_r[QB-1];
endmodule

// ===== src/lrip_range.sv =====
// squares and pipelined square roots for range and horizontal distance
module lrip_range (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  lrip_pkg::stg_t si,
  output lrip_pkg::stg_t so
);
  localparam int NR = lrip_pkg::SQ_STEPS;
  localparam int D = NR + 2;

  lrip_pkg::stg_t tk_r [D];
  lrip_pkg::stg_t tk_nxt [D];
  logic [39:0] sq_r [3];
  logic [39:0] sq_nxt [3];
  logic [41:0] sm_r [2];
  logic [41:0] sm_nxt [2];
  logic [41:0] v_r [NR][2];
  logic [41:0] v_nxt [NR][2];
  logic [23:0] rm_r [NR][2];
  logic [23:0] rm_nxt [NR][2];
  logic [20:0] rt_r [NR][2];
  logic [20:0] rt_nxt [NR][2];

  always_comb begin
    logic signed [39:0] px;
    logic signed [39:0] py;
    logic signed [39:0] pz;
    logic [41:0] pv;
    logic [23:0] prm;
    logic [20:0] prt;
    logic [25:0] cur;
    logic [25:0] trl;
    logic [25:0] df;
    px = si.d.x * si.d.x;
    py = si.d.y * si.d.y;
    pz = si.d.z * si.d.z;
    sq_nxt[0] = unsigned'(px);
    sq_nxt[1] = unsigned'(py);
    sq_nxt[2] = unsigned'(pz);
    sm_nxt[0] = {2'b00, sq_r[0]} + {2'b00, sq_r[1]};
    sm_nxt[1] = {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
    tk_nxt[0] = si;
    for (int k = 1; k < D; k++) begin
      tk_nxt[k] = tk_r[k-1];
    end
    for (int k = 0; k < NR; k++) begin
      for (int ln = 0; ln < 2; ln++) begin
        if (k == 0) begin
          pv = sm_r[ln];
          prm = '0;
          prt = '0;
        end else begin
          pv = v_r[k-1][ln];
          prm = rm_r[k-1][ln];
          prt = rt_r[k-1][ln];
        end
        cur = {prm, pv[41:40]};
        trl = {3'b000, prt, 2'b01};
        df = cur - trl;
        if (cur >= trl) begin
          rm_nxt[k][ln] = df[23:0];
          rt_nxt[k][ln] = {prt[19:0], 1'b1};
        end else begin
          rm_nxt[k][ln] = cur[23:0];
          rt_nxt[k][ln] = {prt[19:0], 1'b0};
        end
        v_nxt[k][ln] = {pv[39:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < D; k++) tk_r[k].vld <= 1'b0;
    end else if (en) begin
      tk_r <= tk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
      sm_r <= sm_nxt;
      v_r <= v_nxt;
      rm_r <= rm_nxt;
      rt_r <= rt_nxt;
    end
  end

  always_comb begin
    so = tk_r[D-1];
    so.d.h = rt_r[NR-1][0][19:0];
    so.d.rng = rt_r[NR-1][1][19:0];
  end
endmodule

// ===== src/lrip_angles.sv =====
// two-lane vectoring cordic for elevation and azimuth
module lrip_angles (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  lrip_pkg::stg_t si,
  output lrip_pkg::stg_t so
);
  localparam int NC = lrip_pkg::CORDIC_STEPS;
  localparam int D = NC + 1;

  lrip_pkg::stg_t tk_r [D];
  lrip_pkg::stg_t tk_nxt [D];
  logic signed [31:0] cx_r [D][2];
  logic signed [31:0] cx_nxt [D][2];
  logic signed [31:0] cy_r [D][2];
  logic signed [31:0] cy_nxt [D][2];
  logic signed [20:0] cz_r [D][2];
  logic signed [20:0] cz_nxt [D][2];
  logic               zf_r [D][2];
  logic               zf_nxt [D][2];

  always_comb begin
    logic signed [20:0] a [2];
    logic signed [20:0] b [2];
    logic signed [20:0] an;
    logic signed [20:0] bn;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    a[0] = 21'(si.d.z);
    b[0] = $signed({1'b0, si.d.h});
    a[1] = 21'(si.d.x);
    b[1] = 21'(si.d.y);
    tk_nxt[0] = si;
    for (int k = 1; k < D; k++) begin
      tk_nxt[k] = tk_r[k-1];
    end
    for (int ln = 0; ln < 2; ln++) begin
      an = b[ln][20] ? -a[ln] : a[ln];
      bn = b[ln][20] ? -b[ln] : b[ln];
      if (!b[ln][20]) cz_nxt[0][ln] = '0;
      else if (a[ln][20]) cz_nxt[0][ln] = -lrip_pkg::Q_PI;
      else cz_nxt[0][ln] = lrip_pkg::Q_PI;
      cx_nxt[0][ln] = {{3{bn[20]}}, bn, 8'h00};
      cy_nxt[0][ln] = {{3{an[20]}}, an, 8'h00};
      zf_nxt[0][ln] = (a[ln] == '0) && (b[ln] == '0);
      for (int k = 1; k < D; k++) begin
        dx = cy_r[k-1][ln] >>> (k - 1);
        dy = cx_r[k-1][ln] >>> (k - 1);
        zf_nxt[k][ln] = zf_r[k-1][ln];
        if (!cy_r[k-1][ln][31]) begin
          cx_nxt[k][ln] = cx_r[k-1][ln] + dx;
          cy_nxt[k][ln] = cy_r[k-1][ln] - dy;
          cz_nxt[k][ln] = cz_r[k-1][ln] + lrip_pkg::ATAN_TAB[k-1];
        end else begin
          cx_nxt[k][ln] = cx_r[k-1][ln] - dx;
          cy_nxt[k][ln] = cy_r[k-1][ln] + dy;
          cz_nxt[k][ln] = cz_r[k-1][ln] - lrip_pkg::ATAN_TAB[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < D; k++) tk_r[k].vld <= 1'b0;
    end else if (en) begin
      tk_r <= tk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
      zf_r <= zf_nxt;
    end
  end

  always_comb begin
    so = tk_r[D-1];
    so.d.elev = zf_r[D-1][0] ? '0 : cz_r[D-1][0];
    so.d.azim = zf_r[D-1][1] ? '0 : cz_r[D-1][1];
  end
endmodule

// ===== src/lrip_bins.sv =====
// row and column binning, rejection and image indexes
module lrip_bins #(
  parameter int ROWS = 16,
  parameter int COLUMNS = 1800,
  parameter int PATCH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic [17:0]    row_angle_offset,
  input  logic [17:0]    row_angle_step,
  input  logic [19:0]    min_range,
  input  lrip_pkg::stg_t si,
  output lrip_pkg::stg_t so
);
  localparam int RB = $clog2(ROWS);
  localparam int CMW = 23 + $clog2(COLUMNS);
  localparam int RCW = (18 + RB > 22) ? 18 + RB : 22;
  localparam int TW = $clog2(COLUMNS) + 5;
  localparam int DS = RB + 2;
  localparam int D = RB + 7;
  localparam int SH = 20;
  localparam int CS = 52;
  localparam int NCELL = COLUMNS / PATCH;
  localparam logic [39:0] PM = 40'(((1 << SH) + PATCH - 1) / PATCH);
  localparam logic [64:0] CREC_W =
    ((65'd1 << CS) + 65'(lrip_pkg::COL_DEN) - 65'd1) / 65'(lrip_pkg::COL_DEN);
  localparam logic [32:0] CREC = CREC_W[32:0];
  localparam logic signed [CMW-1:0] COLS_M = CMW'(COLUMNS);
  localparam logic signed [TW-1:0] COLS_T = TW'(COLUMNS);

  lrip_pkg::stg_t tk_r [D];
  lrip_pkg::stg_t tk_nxt [D];
  logic signed [21:0]    rn_r, rn_nxt;
  logic signed [21:0]    da_r, da_nxt;
  logic [21:0]           rmag_r, rmag_nxt;
  logic signed [CMW-1:0] cn_r, cn_nxt;
  logic [31:0]           cd_r, cd_nxt;
  logic [RB-1:0]         rquo;

  lrip_div #(.NW(22), .DW(18), .QB(RB)) u_row_div (
    .clk(clk), .en(en), .num(rmag_r), .den(row_angle_step), .quo(rquo)
  );

  always_comb begin
    logic signed [21:0] rm;
    logic signed [CMW-1:0] cm;
    logic [64:0] cpr;
    logic signed [TW-1:0] qs;
    logic signed [TW-1:0] tt;
    logic signed [TW-1:0] hf;
    logic rowbad;
    logic colbad;
    logic near;
    logic [31:0] ti;
    logic [31:0] tr;
    logic [39:0] tc;
    logic [31:0] ta;
    logic [31:0] tb;
    logic [31:0] tl;
    logic [31:0] tp;
    lrip_pkg::pt_t p;

    tk_nxt[0] = si;
    for (int k = 1; k < D; k++) begin
      tk_nxt[k] = tk_r[k-1];
    end

    rn_nxt = 22'(si.d.elev) + $signed({4'b0000, row_angle_offset});
    da_nxt = 22'(si.d.azim) - 22'(lrip_pkg::Q_HALF_PI);

    rm = rn_r[21] ? -rn_r : rn_r;
    rmag_nxt = unsigned'(rm);
    tk_nxt[1].d.rneg = rn_r[21];
    tk_nxt[1].d.rbad = (row_angle_step == '0) ||
                       (RCW'(rmag_nxt) >= (RCW'(row_angle_step) << RB));
    cn_nxt = CMW'(da_r) * COLS_M;

    cm = cn_r[CMW-1] ? -cn_r : cn_r;
    tk_nxt[2].d.cneg = cn_r[CMW-1];
    cd_nxt = 32'({unsigned'(cm), 1'b0}) + 32'(unsigned'(lrip_pkg::Q_TWO_PI));

    // reciprocal scaling gives the exact quotient for any 32-bit numerator
    cpr = 65'(cd_r) * 65'(CREC);
    tk_nxt[3].d.cq = cpr[CS+12:CS];

    tk_nxt[RB+2].d.rq = 7'(rquo);

    p = tk_r[DS].d;
    rowbad = p.rbad || (p.rneg && (p.rq != '0)) || ({1'b0, p.rq} >= 8'(ROWS));
    qs = p.cneg ? -TW'(p.cq) : TW'(p.cq);
    tt = COLS_T - (qs <<< 1);
    hf = tt[TW-1] ? -((-tt) >>> 1) : (tt >>> 1);
    if (hf >= COLS_T) hf = hf - COLS_T;
    colbad = hf[TW-1] || (hf >= COLS_T);
    near = (p.rng == '0) || (p.rng < min_range);
    if (rowbad) tk_nxt[DS+1].d.status = lrip_pkg::ST_ROW;
    else if (colbad) tk_nxt[DS+1].d.status = lrip_pkg::ST_COL;
    else if (near) tk_nxt[DS+1].d.status = lrip_pkg::ST_NEAR;
    else tk_nxt[DS+1].d.status = lrip_pkg::ST_OK;
    if (!rowbad && !colbad && !near) begin
      tk_nxt[DS+1].d.row = p.rq;
      tk_nxt[DS+1].d.col = 12'(hf);
    end else begin
      tk_nxt[DS+1].d.row = '0;
      tk_nxt[DS+1].d.col = '0;
    end

    p = tk_r[DS+1].d;
    ti = 32'(p.row) * 32'(COLUMNS) + 32'(p.col);
    tr = 32'(p.row) * PM[31:0];
    tc = 40'(p.col) * PM;
    tk_nxt[DS+2].d.img = ti[14:0];
    tk_nxt[DS+2].d.qr = tr[SH+6:SH];
    tk_nxt[DS+2].d.qc = tc[SH+11:SH];

    p = tk_r[DS+2].d;
    ta = 32'(p.row) - 32'(p.qr) * 32'(PATCH);
    tb = 32'(p.col) - 32'(p.qc) * 32'(PATCH);
    tl = 32'(p.qr) * 32'(NCELL) + 32'(p.qc);
    tk_nxt[DS+3].d.rr = ta[3:0];
    tk_nxt[DS+3].d.rc = tb[3:0];
    tk_nxt[DS+3].d.tile = tl[14:0];

    p = tk_r[DS+3].d;
    tp = 32'(p.tile) * 32'(PATCH * PATCH) + 32'(p.rr) * 32'(PATCH) + 32'(p.rc);
    tk_nxt[DS+4].d.patch = tp[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < D; k++) tk_r[k].vld <= 1'b0;
    end else if (en) begin
      tk_r <= tk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rn_r <= rn_nxt;
      da_r <= da_nxt;
      rmag_r <= rmag_nxt;
      cn_r <= cn_nxt;
      cd_r <= cd_nxt;
    end
  end

  assign so = tk_r[D-1];
endmodule

// ===== src/lidar_point_range_image_projection_top.sv =====
// top level of the lidar point to range image projection pipeline
// Takes one point word per cycle while no output word is held, and returns one
// result word per point, in order. A point passes through squaring and bit-per-stage
// square roots, then the two-lane cordic, then row division, column scaling and
// index arithmetic, where the row divider takes one quotient bit per stage.
// A held output word stalls the whole pipeline together; nothing is dropped.
// Configuration registers are to be written over the apb port only while no point
// is in flight.
module lidar_point_range_image_projection_top #(
  parameter int ROWS = 16,
  parameter int COLUMNS = 1800,
  parameter int PATCH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  lrip_in_if.sink     in_ch,
  lrip_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [17:0] off_r, off_nxt;
  logic [17:0] step_r, step_nxt;
  logic [19:0] minr_r, minr_nxt;
  logic        wr;
  logic        adv;
  lrip_pkg::stg_t s_in, s_rng, s_ang, s_out;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    off_nxt = off_r;
    step_nxt = step_r;
    minr_nxt = minr_r;
    if (wr) begin
      unique case (cfg_paddr[3:2])
        lrip_pkg::REG_OFFSET: off_nxt = cfg_pwdata[17:0];
        lrip_pkg::REG_STEP:   step_nxt = cfg_pwdata[17:0];
        lrip_pkg::REG_MINR:   minr_nxt = cfg_pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= lrip_pkg::OFFSET_RST;
      step_r <= lrip_pkg::STEP_RST;
      minr_r <= lrip_pkg::MINR_RST;
    end else begin
      off_r <= off_nxt;
      step_r <= step_nxt;
      minr_r <= minr_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      lrip_pkg::REG_OFFSET: cfg_prdata = {14'd0, off_r};
      lrip_pkg::REG_STEP:   cfg_prdata = {14'd0, step_r};
      lrip_pkg::REG_MINR:   cfg_prdata = {12'd0, minr_r};
      default:              cfg_prdata = '0;
    endcase
  end

  assign adv = !s_out.vld || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    s_in = '0;
    s_in.vld = in_ch.valid;
    s_in.d.x = in_ch.x_pos;
    s_in.d.y = in_ch.y_pos;
    s_in.d.z = in_ch.z_pos;
  end

  lrip_range u_range (.clk(clk), .rst_n(rst_n), .en(adv), .si(s_in), .so(s_rng));

  lrip_angles u_angles (.clk(clk), .rst_n(rst_n), .en(adv), .si(s_rng), .so(s_ang));

  lrip_bins #(.ROWS(ROWS), .COLUMNS(COLUMNS), .PATCH(PATCH)) u_bins (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .row_angle_offset(off_r), .row_angle_step(step_r), .min_range(minr_r),
    .si(s_ang), .so(s_out)
  );

  assign out_ch.valid = s_out.vld;
  assign out_ch.status = s_out.d.status;
  assign out_ch.row = s_out.d.row[3:0];
  assign out_ch.column = s_out.d.col[10:0];
  assign out_ch.distance = s_out.d.rng;
  assign out_ch.image_index = s_out.d.img;
  assign out_ch.patch_index = s_out.d.patch;
endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the lidar range image projection block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS = 16;
  localparam int NCOLS = 1800;
  localparam int NPATCH = 4;
  localparam int LATENCY = 51;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
  } point_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  row;
    logic [10:0] column;
    logic [19:0] distance;
    logic [14:0] image_index;
    logic [14:0] patch_index;
  } proj_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lrip_in_if in_ch();
  lrip_out_if out_ch();

  lidar_point_range_image_projection_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  logic [17:0] angle_offset = lrip_pkg::OFFSET_RST;
  logic [17:0] angle_step = lrip_pkg::STEP_RST;
  logic [19:0] near_limit = lrip_pkg::MINR_RST;

  point_t pending_points[$];
  proj_t  expected_proj[$];
  int     mismatch_count = 0;
  longint cycle_count = 0;
  bit     hold_off = 1'b0;

  function automatic void add_point(point_t p);
    pending_points.insert(pending_points.size(), p);
  endfunction

  function automatic longint shift_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint acc, bit_v;
    acc = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= acc + bit_v) begin
        v = v - (acc + bit_v);
        acc = (acc >> 1) + bit_v;
      end else begin
        acc = acc >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return acc;
  endfunction

  function automatic longint cordic_angle(longint a, longint b);
    longint cx, cy, ang, off, dx, dy;
    ang = 0;
    off = 0;
    if (a == 0 && b == 0) return 0;
    if (b < 0) begin
      off = (a >= 0) ? longint'(lrip_pkg::Q_PI) : -longint'(lrip_pkg::Q_PI);
      a = -a;
      b = -b;
    end
    cx = b * 256;
    cy = a * 256;
    for (int i = 0; i < lrip_pkg::CORDIC_STEPS; i++) begin
      dx = shift_floor(cy, i);
      dy = shift_floor(cx, i);
      if (cy >= 0) begin
        cx += dx; cy -= dy; ang += longint'(lrip_pkg::ATAN_TAB[i]);
      end else begin
        cx -= dx; cy += dy; ang -= longint'(lrip_pkg::ATAN_TAB[i]);
      end
    end
    return ang + off;
  endfunction

  function automatic proj_t project_point(point_t p);
    proj_t r;
    longint x, y, z, hsq, rng, hdist, elev, azim, rowv, colv, num, mag, q;
    longint tile;
    x = p.x; y = p.y; z = p.z;
    hsq = x * x + y * y;
    rng = int_sqrt(hsq + z * z);
    hdist = int_sqrt(hsq);
    elev = cordic_angle(z, hdist);
    azim = cordic_angle(x, y);
    r = '0;
    r.distance = (rng > 20'hFFFFF) ? 20'hFFFFF : rng[19:0];
    r.status = lrip_pkg::ST_OK;
    rowv = 0;
    colv = 0;
    if (angle_step == 0) begin
      r.status = lrip_pkg::ST_ROW;
    end else begin
      rowv = (elev + longint'(angle_offset)) / longint'(angle_step);
      if (rowv < 0 || rowv >= NROWS) r.status = lrip_pkg::ST_ROW;
    end
    if (r.status == lrip_pkg::ST_OK) begin
      num = (azim - longint'(lrip_pkg::Q_HALF_PI)) * NCOLS;
      mag = num < 0 ? -num : num;
      q = (2 * mag + longint'(lrip_pkg::Q_TWO_PI)) / (2 * longint'(lrip_pkg::Q_TWO_PI));
      if (num < 0) q = -q;
      colv = (NCOLS - 2 * q) / 2;
      if (colv >= NCOLS) colv -= NCOLS;
      if (colv < 0 || colv >= NCOLS) r.status = lrip_pkg::ST_COL;
    end
    if (r.status == lrip_pkg::ST_OK && (rng == 0 || rng < longint'(near_limit)))
      r.status = lrip_pkg::ST_NEAR;
    if (r.status == lrip_pkg::ST_OK) begin
      tile = ((rowv / NPATCH) * (NCOLS / NPATCH) + colv / NPATCH) * NPATCH * NPATCH
             + (rowv % NPATCH) * NPATCH + colv % NPATCH;
      r.row = rowv[3:0];
      r.column = colv[10:0];
      r.image_index = 15'(colv + rowv * NCOLS);
      r.patch_index = tile[14:0];
    end
    return r;
  endfunction

  // input driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.x_pos <= '0;
      in_ch.y_pos <= '0;
      in_ch.z_pos <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) pending_points.pop_front();
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        point_t nxt;
        nxt = pending_points[0];
        in_ch.valid <= 1'b1;
        in_ch.x_pos <= nxt.x;
        in_ch.y_pos <= nxt.y;
        in_ch.z_pos <= nxt.z;
        expected_proj.insert(expected_proj.size(), project_point(nxt));
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_proj.size() == 0) begin
          $error("unexpected result word");
          mismatch_count++;
        end else begin
          proj_t e;
          e = expected_proj.pop_front();
          if (out_ch.status !== e.status) begin
            $error("status expected %0d got %0d", e.status, out_ch.status); mismatch_count++;
          end
          if (out_ch.row !== e.row) begin
            $error("row expected %0d got %0d", e.row, out_ch.row); mismatch_count++;
          end
          if (out_ch.column !== e.column) begin
            $error("column expected %0d got %0d", e.column, out_ch.column); mismatch_count++;
          end
          if (out_ch.distance !== e.distance) begin
            $error("distance expected %0d got %0d", e.distance, out_ch.distance);
            mismatch_count++;
          end
          if (out_ch.image_index !== e.image_index) begin
            $error("image_index expected %0d got %0d", e.image_index, out_ch.image_index);
            mismatch_count++;
          end
          if (out_ch.patch_index !== e.patch_index) begin
            $error("patch_index expected %0d got %0d", e.patch_index, out_ch.patch_index);
            mismatch_count++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 23;
      out_ch.ready <= !hold_off && (stall_phase < 12 || $urandom_range(0, 2) != 0);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      lrip_pkg::REG_OFFSET: angle_offset = val[17:0];
      lrip_pkg::REG_STEP:   angle_step = val[17:0];
      default:              near_limit = val[19:0];
    endcase
  endtask

  task automatic drain();
    while (pending_points.size() != 0 || in_ch.valid || expected_proj.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic point_t rand_point();
    point_t p;
    int mode;
    mode = $urandom_range(0, 3);
    p.x = 20'($urandom);
    p.y = 20'($urandom);
    p.z = 20'($urandom);
    if (mode == 0) begin
      p.x = 20'(int'($urandom_range(0, 4000)) - 2000);
      p.y = 20'(int'($urandom_range(0, 4000)) - 2000);
      p.z = 20'(int'($urandom_range(0, 400)) - 200);
    end else if (mode == 1) begin
      p.z = p.z >>> $urandom_range(2, 8);
    end
    return p;
  endfunction

  task automatic add_directed();
    int ext [4] = '{-524288, 524287, 0, 1};
    add_point('{20'sd0, 20'sd0, 20'sd0});
    add_point('{20'sd30, 20'sd40, 20'sd0});
    add_point('{20'sd0, 20'sd10000, 20'sd0});
    add_point('{20'sd0, -20'sd10000, 20'sd0});
    add_point('{-20'sd10000, 20'sd0, 20'sd0});
    add_point('{20'sd10000, 20'sd0, 20'sd100});
    add_point('{20'sd10000, 20'sd0, 20'sd9000});
    add_point('{20'sd10000, 20'sd0, -20'sd9000});
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        add_point('{20'(ext[i]), 20'(ext[j]), 20'(ext[(i + j) % 4])});
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    add_directed();
    drain();
    // long receiver hold-off while the sender keeps offering
    for (int i = 0; i < 150; i++) add_point(rand_point());
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
    drain();
    cfg_write(lrip_pkg::REG_STEP, 32'd0);
    for (int i = 0; i < 10; i++) add_point(rand_point());
    drain();
    cfg_write(lrip_pkg::REG_OFFSET, 32'h3FFFF);
    cfg_write(lrip_pkg::REG_STEP, 32'h3FFFF);
    cfg_write(lrip_pkg::REG_MINR, 32'hFFFFF);
    for (int i = 0; i < 20; i++) add_point(rand_point());
    drain();
    cfg_write(lrip_pkg::REG_OFFSET, 32'd0);
    cfg_write(lrip_pkg::REG_STEP, 32'd1);
    cfg_write(lrip_pkg::REG_MINR, 32'd0);
    add_point('{20'sd0, 20'sd0, 20'sd0});
    for (int i = 0; i < 10; i++) add_point(rand_point());
    drain();
    cfg_write(lrip_pkg::REG_OFFSET, 32'd40000);
    cfg_write(lrip_pkg::REG_STEP, 32'd5000);
    cfg_write(lrip_pkg::REG_MINR, 32'd500);
    for (int i = 0; i < 100; i++) add_point(rand_point());
    drain();
    cfg_write(lrip_pkg::REG_OFFSET, 32'(lrip_pkg::OFFSET_RST));
    cfg_write(lrip_pkg::REG_STEP, 32'(lrip_pkg::STEP_RST));
    cfg_write(lrip_pkg::REG_MINR, 32'(lrip_pkg::MINR_RST));
    for (int i = 0; i < 120; i++) add_point(rand_point());
    drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== lidar_point_range_image_projection_top.f =====
src/lrip_pkg.sv
src/lrip_in_if.sv
src/lrip_out_if.sv
src/lrip_div.sv
src/lrip_range.sv
src/lrip_angles.sv
src/lrip_bins.sv
src/lidar_point_range_image_projection_top.sv
tb/tb_top.sv
